// File: design/tx_round_trip_slot_table_core_macros.svh
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Shared concurrent assertion shorthands for the slot table core.
// ----------------------------------------------------------------------------
`ifndef TX_ROUND_TRIP_SLOT_TABLE_CORE_MACROS_SVH
`define TX_ROUND_TRIP_SLOT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rtst_pkg.sv
// ----------------------------------------------------------------------------
// Slot table package
// Field widths, command codes and item types of the slot table core.
// ----------------------------------------------------------------------------
package rtst_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned GAP_W   = 32;
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned DELAY_W = 16;

  // Upper bound (exclusive) for a usable delay sample
  localparam logic [GAP_W-1:0] GAP_LIMIT = 32'd60000;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_REPLY   = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                command;
    logic [ADDR_W-1:0]   peer_addr;
    logic [SEL_W-1:0]    slot_sel;
    logic [TIME_W-1:0]   now_us;
  } req_t;

  typedef struct packed {
    logic [SEL_W-1:0]    slot_out;
    logic                hit;
    logic [DELAY_W-1:0]  delay_out;
  } res_t;

  // One entry of the timing memory
  typedef struct packed {
    logic [TIME_W-1:0]   since;
    logic [GAP_W-1:0]    gap;
  } slot_time_t;

endpackage

// File: design/rtst_if.sv
// ----------------------------------------------------------------------------
// Slot table channels
// Valid/ready request and result channels of the slot table core.
// ----------------------------------------------------------------------------
interface rtst_in_if;
  import rtst_pkg::*;

  logic                valid;
  logic                ready;
  cmd_e                command;
  logic [ADDR_W-1:0]   peer_addr;
  logic [SEL_W-1:0]    slot_sel;
  logic [TIME_W-1:0]   now_us;

  modport source (output valid, command, peer_addr, slot_sel, now_us, input ready);
  modport sink   (input valid, command, peer_addr, slot_sel, now_us, output ready);
endinterface

interface rtst_out_if;
  import rtst_pkg::*;

  logic                valid;
  logic                ready;
  logic [SEL_W-1:0]    slot_out;
  logic                hit;
  logic [DELAY_W-1:0]  delay_out;

  modport source (output valid, slot_out, hit, delay_out, input ready);
  modport sink   (input valid, slot_out, hit, delay_out, output ready);
endinterface

// File: design/tx_round_trip_slot_table_core.sv
// ----------------------------------------------------------------------------
// Transmit round-trip slot table
// Claims slots per peer, stamps sends and measures reply delay per slot.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   in_i     in   command, peer_addr, slot_sel, now_us
//   out_o    out  slot_out, hit, delay_out
//
// One item at a time. Send on a valid slot does one memory read, then
// write-back; reply searches the table, reading one entry of the slot
// memories per cycle.
// Reset clears busy and pending marks only; memory contents stay undefined.
// A result held in the output register does not block the next item.
module tx_round_trip_slot_table_core #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtst_in_if.sink    in_i,
  rtst_out_if.source out_o
);
  import rtst_pkg::*;

  req_t req;
  res_t res;
  res_t out_res_q;
  logic res_valid;
  logic res_ready;
  logic out_valid_q;

  assign req.command   = in_i.command;
  assign req.peer_addr = in_i.peer_addr;
  assign req.slot_sel  = in_i.slot_sel;
  assign req.now_us    = in_i.now_us;

  rtst_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.slot_out  = out_res_q.slot_out;
  assign out_o.hit       = out_res_q.hit;
  assign out_o.delay_out = out_res_q.delay_out;

endmodule

// File: design/rtst_ram.sv
// ----------------------------------------------------------------------------
// Slot table RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rtst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rtst_ctrl.sv
// ----------------------------------------------------------------------------
// Slot table sequencer
// Runs one command at a time against the peer and timing memories.
// ----------------------------------------------------------------------------
`include "tx_round_trip_slot_table_core_macros.svh"

module rtst_ctrl #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rtst_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output rtst_pkg::res_t res_o
);
  import rtst_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned TM_W  = $bits(slot_time_t);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACQ,
    ST_SEND_RD,
    ST_SEND_WR,
    ST_SCAN,
    ST_REL,
    ST_RESULT
  } state_e;

  state_e                state_q;
  req_t                  req_q;
  res_t                  res_q;
  logic [SLOT_COUNT-1:0] busy_q;
  logic [SLOT_COUNT-1:0] pend_q;
  logic [CNT_W-1:0]      scan_q;
  logic [IDX_W-1:0]      chk_idx_q;
  logic                  chk_v_q;

  logic                  sel_ok;
  logic [IDX_W-1:0]      sel_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  match;
  logic [GAP_W-1:0]      elapsed;

  logic                  peer_we;
  logic                  time_we;
  logic [IDX_W-1:0]      time_waddr;
  slot_time_t            time_wdata;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;
  logic [ADDR_W-1:0]     peer_rdata;
  slot_time_t            time_rdata;
  logic [TM_W-1:0]       time_rdata_raw;

  function automatic logic [DELAY_W-1:0] clamp_gap(input logic [GAP_W-1:0] gap);
    return (gap != '0 && gap < GAP_LIMIT) ? gap[DELAY_W-1:0] : '0;
  endfunction

  assign sel_ok  = (32'(req_q.slot_sel) < SLOT_COUNT);
  assign sel_idx = IDX_W'(req_q.slot_sel);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign time_rdata = slot_time_t'(time_rdata_raw);
  assign match   = chk_v_q && busy_q[chk_idx_q] && pend_q[chk_idx_q] &&
                   (peer_rdata == req_q.peer_addr);
  assign elapsed = req_q.now_us[GAP_W-1:0] - time_rdata.since[GAP_W-1:0];

  // Read port: send reads its slot, reply walks the table one entry a cycle
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = '0;
    case (state_q)
      ST_SEND_RD: begin
        rd_en  = sel_ok;
        rd_idx = sel_idx;
      end
      ST_SCAN: begin
        rd_en  = (scan_q < SLOT_CNT);
        rd_idx = scan_q[IDX_W-1:0];
      end
      default: begin
        rd_en  = 1'b0;
        rd_idx = '0;
      end
    endcase
  end

  // Write port
  always_comb begin
    peer_we    = 1'b0;
    time_we    = 1'b0;
    time_waddr = '0;
    time_wdata = '0;
    case (state_q)
      ST_ACQ: begin
        peer_we    = free_found;
        time_we    = free_found;
        time_waddr = free_idx;
      end
      ST_SEND_WR: begin
        time_we          = 1'b1;
        time_waddr       = sel_idx;
        time_wdata.since = req_q.now_us;
        time_wdata.gap   = time_rdata.gap;
      end
      ST_SCAN: begin
        time_we          = match;
        time_waddr       = chk_idx_q;
        time_wdata.since = time_rdata.since;
        time_wdata.gap   = elapsed;
      end
      default: begin
        time_we = 1'b0;
      end
    endcase
  end

  rtst_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (SLOT_COUNT)
  ) u_peer_ram (
    .clk_i   (clk_i),
    .we_i    (peer_we),
    .waddr_i (free_idx),
    .wdata_i (req_q.peer_addr),
    .re_i    (rd_en),
    .raddr_i (rd_idx),
    .rdata_o (peer_rdata)
  );

  rtst_ram #(
    .WIDTH (TM_W),
    .DEPTH (SLOT_COUNT)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (time_waddr),
    .wdata_i (time_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx),
    .rdata_o (time_rdata_raw)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESULT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_q     <= '0;
      busy_q    <= '0;
      pend_q    <= '0;
      scan_q    <= '0;
      chk_idx_q <= '0;
      chk_v_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          scan_q  <= '0;
          chk_v_q <= 1'b0;
          if (req_valid_i) begin
            case (req_i.command)
              CMD_ACQUIRE: state_q <= ST_ACQ;
              CMD_SEND:    state_q <= ST_SEND_RD;
              CMD_REPLY:   state_q <= ST_SCAN;
              CMD_RELEASE: state_q <= ST_REL;
              default:     state_q <= ST_REL;
            endcase
          end
        end
        ST_ACQ: begin
          if (free_found) begin
            busy_q[free_idx] <= 1'b1;
            pend_q[free_idx] <= 1'b0;
            res_q <= '{slot_out: SEL_W'(free_idx), hit: 1'b1, delay_out: '0};
          end else begin
            res_q <= '0;
          end
          state_q <= ST_RESULT;
        end
        ST_SEND_RD: begin
          res_q <= '0;
          state_q <= sel_ok ? ST_SEND_WR : ST_RESULT;
        end
        ST_SEND_WR: begin
          pend_q[sel_idx] <= 1'b1;
          res_q.delay_out <= clamp_gap(time_rdata.gap);
          state_q         <= ST_RESULT;
        end
        ST_SCAN: begin
          if (match) begin
            pend_q[chk_idx_q] <= 1'b0;
            res_q <= '{slot_out: SEL_W'(chk_idx_q), hit: 1'b1, delay_out: '0};
            state_q           <= ST_RESULT;
          end else if (chk_v_q && chk_idx_q == LAST_IDX) begin
            res_q   <= '0;
            state_q <= ST_RESULT;
          end else begin
            // compare stage checks the entry read in the previous cycle
            chk_v_q   <= (scan_q < SLOT_CNT);
            chk_idx_q <= scan_q[IDX_W-1:0];
            if (scan_q < SLOT_CNT) begin
              scan_q <= scan_q + CNT_W'(1);
            end
          end
        end
        ST_REL: begin
          if (sel_ok) begin
            busy_q[sel_idx] <= 1'b0;
          end
          res_q   <= '0;
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `RTST_ASSERT_IMP(a_no_write_idle, state_q == ST_IDLE, !time_we && !peer_we, "write while idle")
  `RTST_ASSERT_NXT(a_reply_clears_pend, state_q == ST_SCAN && match, !pend_q[$past(chk_idx_q)], "reply left pending mark")
  `RTST_ASSERT_NXT(a_acquire_sets_busy, state_q == ST_ACQ && free_found, busy_q[$past(free_idx)], "acquire did not claim slot")
  `RTST_ASSERT_NXT(a_send_sets_pend, state_q == ST_SEND_WR, pend_q[$past(sel_idx)], "send did not mark pending")

endmodule

// File: dv/tx_round_trip_slot_table_core_checker.sv
// ----------------------------------------------------------------------------
// Slot table scoreboard
// Mirrors the slot table from accepted request items and checks every result
// item, in order and field by field, against the predicted one.
// ----------------------------------------------------------------------------
module tx_round_trip_slot_table_core_checker #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtst_in_if          req_i,
  rtst_out_if         res_i,
  output int unsigned fail_cnt_o,
  output int unsigned open_cnt_o,
  output int unsigned reply_hit_cnt_o,
  output int unsigned delay_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtst_pkg::*;

  logic [SLOT_COUNT-1:0] busy_q;
  logic [SLOT_COUNT-1:0] pend_q;
  logic [ADDR_W-1:0]     peer_q  [SLOT_COUNT];
  logic [TIME_W-1:0]     since_q [SLOT_COUNT];
  logic [GAP_W-1:0]      gap_q   [SLOT_COUNT];
  res_t                  expected_res_q [$];

  // usable sample only when positive as signed 32 bits and under the limit
  function automatic logic [DELAY_W-1:0] clamp_delay(logic [GAP_W-1:0] gap);
    if ($signed(gap) > 0 && gap < GAP_LIMIT) return gap[DELAY_W-1:0];
    return '0;
  endfunction

  task automatic predict_slot_result(input req_t req, output res_t res);
    bit found;
    found = 1'b0;
    res   = '0;
    case (req.command)
      CMD_ACQUIRE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && !busy_q[i]) begin
            busy_q[i]    = 1'b1;
            peer_q[i]    = req.peer_addr;
            pend_q[i]    = 1'b0;
            since_q[i]   = '0;
            gap_q[i]     = '0;
            res.slot_out = SEL_W'(i);
            res.hit      = 1'b1;
            found        = 1'b1;
          end
        end
      end
      CMD_SEND: begin
        if (req.slot_sel < SLOT_COUNT) begin
          res.delay_out          = clamp_delay(gap_q[req.slot_sel]);
          since_q[req.slot_sel]  = req.now_us;
          pend_q[req.slot_sel]   = 1'b1;
          if (res.delay_out != '0) delay_cnt_o++;
        end
      end
      CMD_REPLY: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && busy_q[i] && pend_q[i] && peer_q[i] == req.peer_addr) begin
            gap_q[i]     = GAP_W'(req.now_us - since_q[i]);
            pend_q[i]    = 1'b0;
            res.slot_out = SEL_W'(i);
            res.hit      = 1'b1;
            found        = 1'b1;
            reply_hit_cnt_o++;
          end
        end
      end
      default: begin
        if (req.slot_sel < SLOT_COUNT) busy_q[req.slot_sel] = 1'b0;
      end
    endcase
  endtask

  // sampled at the rising edge; the block and the stimulus both change later
  always @(posedge clk_i) begin : monitor
    req_t req;
    res_t got;
    res_t want;
    if (!rst_ni) begin
      busy_q = '0;
      pend_q = '0;
      expected_res_q.delete();
    end else begin
      // retire first, so a stray result never pairs with a same-edge request
      if (res_i.valid && res_i.ready) begin
        got = '{slot_out: res_i.slot_out, hit: res_i.hit, delay_out: res_i.delay_out};
        if (expected_res_q.size() == 0) begin
          $display("%0t: unexpected result item: slot_out %0d hit %0b delay_out %0d",
                   $time, got.slot_out, got.hit, got.delay_out);
          fail_cnt_o++;
        end else begin
          want = expected_res_q.pop_front();
          if (got.slot_out != want.slot_out) begin
            $display("%0t: slot_out mismatch: expected %0d actual %0d",
                     $time, want.slot_out, got.slot_out);
            fail_cnt_o++;
          end
          if (got.hit != want.hit) begin
            $display("%0t: hit mismatch: expected %0b actual %0b",
                     $time, want.hit, got.hit);
            fail_cnt_o++;
          end
          if (got.delay_out != want.delay_out) begin
            $display("%0t: delay_out mismatch: expected %0d actual %0d",
                     $time, want.delay_out, got.delay_out);
            fail_cnt_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        req = '{command: req_i.command, peer_addr: req_i.peer_addr,
                slot_sel: req_i.slot_sel, now_us: req_i.now_us};
        predict_slot_result(req, want);
        expected_res_q.push_back(want);
      end
    end
    open_cnt_o = expected_res_q.size();
  end

endmodule

// File: dv/tx_round_trip_slot_table_core_tb.sv
// ----------------------------------------------------------------------------
// Slot table testbench
// Drives directed and random command items into the slot table core with
// varying idle and stall patterns; the scoreboard beside it checks results.
// ----------------------------------------------------------------------------
module tx_round_trip_slot_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtst_pkg::*;

  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned RAND_ITEMS  = 1050;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  rtst_in_if  in_if ();
  rtst_out_if out_if ();

  int unsigned fail_cnt;
  int unsigned open_cnt;
  int unsigned reply_hits;
  int unsigned delay_samples;

  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  bit          hold_req;

  // what the table holds, as far as the stimulus needs to know
  logic [SLOT_COUNT-1:0] shadow_busy;
  logic [ADDR_W-1:0]     shadow_peer [SLOT_COUNT];
  logic [ADDR_W-1:0]     addr_pool   [8];
  logic [TIME_W-1:0]     clock_us;
  int unsigned           item_cnt;
  int unsigned           cmd_cnt     [4];

  tx_round_trip_slot_table_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  tx_round_trip_slot_table_core_checker #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (in_if),
    .res_i          (out_if),
    .fail_cnt_o     (fail_cnt),
    .open_cnt_o     (open_cnt),
    .reply_hit_cnt_o(reply_hits),
    .delay_cnt_o    (delay_samples)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d result items outstanding", open_cnt);
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(4) == 0) return ADDR_W'(rand_wide());
    return addr_pool[$urandom_range(7)];
  endfunction

  // elapsed time for a reply, aimed at the clamp boundaries
  function automatic logic [TIME_W-1:0] pick_delta();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIME_W'(GAP_LIMIT);
      2:       return TIME_W'(GAP_LIMIT) - 1;
      3:       return 64'd1;
      4:       return TIME_W'($urandom_range(32'h7FFF_FFFF, 60001));
      5:       return {32'h0, $urandom} | 64'h8000_0000;
      6:       return rand_wide();
      default: return TIME_W'($urandom_range(59998, 1));
    endcase
  endfunction

  // starts and ends at a falling edge
  task automatic put_item(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                          input logic [SEL_W-1:0] sel, input logic [TIME_W-1:0] now);
    bit done;
    done = 1'b0;
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.peer_addr <= addr;
    in_if.slot_sel  <= sel;
    in_if.now_us    <= now;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    case (cmd)
      CMD_ACQUIRE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!done && !shadow_busy[i]) begin
            shadow_busy[i] = 1'b1;
            shadow_peer[i] = addr;
            done           = 1'b1;
          end
        end
      end
      CMD_RELEASE: shadow_busy[sel] = 1'b0;
      default: ;
    endcase
    cmd_cnt[cmd]++;
    item_cnt++;
  endtask

  // stop offering until every expected result item has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (open_cnt != 0);
  endtask

  task automatic noise_item();
    logic [TIME_W-1:0] now;
    now = ($urandom_range(3) == 0) ? rand_wide() : clock_us;
    case ($urandom_range(3))
      0:       put_item(CMD_ACQUIRE, pick_addr(), SEL_W'($urandom), now);
      1:       put_item(CMD_SEND, ADDR_W'(rand_wide()), SEL_W'($urandom), now);
      2:       put_item(CMD_REPLY, pick_addr(), SEL_W'($urandom), now);
      default: put_item(CMD_RELEASE, ADDR_W'(rand_wide()), SEL_W'($urandom), now);
    endcase
  endtask

  // send on a busy slot, answer it from its peer, then read the delay back
  task automatic round_trip();
    logic [SEL_W-1:0]  s;
    logic [TIME_W-1:0] t0;
    if (shadow_busy == '0) put_item(CMD_ACQUIRE, pick_addr(), SEL_W'($urandom), clock_us);
    do s = SEL_W'($urandom_range(SLOT_COUNT - 1)); while (!shadow_busy[s]);
    clock_us += $urandom_range(500, 1);
    t0 = clock_us;
    put_item(CMD_SEND, ADDR_W'(rand_wide()), s, t0);
    if ($urandom_range(3) == 0) noise_item();
    put_item(CMD_REPLY, shadow_peer[s], SEL_W'($urandom), t0 + pick_delta());
    clock_us += $urandom_range(500);
    put_item(CMD_SEND, ADDR_W'(rand_wide()), s, clock_us);
  endtask

  task automatic random_step();
    logic [SEL_W-1:0] s;
    if ($countones(shadow_busy) > 5 && $urandom_range(2) == 0) begin
      do s = SEL_W'($urandom_range(SLOT_COUNT - 1)); while (!shadow_busy[s]);
      put_item(CMD_RELEASE, ADDR_W'(rand_wide()), s, clock_us);
    end else if ($urandom_range(9) < 6) begin
      round_trip();
    end else begin
      noise_item();
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned waited;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_ACQUIRE;
    in_if.peer_addr = '0;
    in_if.slot_sel  = '0;
    in_if.now_us    = '0;
    send_gap_pct    = 0;
    recv_gap_pct    = 0;
    hold_req        = 1'b0;
    shadow_busy     = '0;
    item_cnt        = 0;
    addr_pool[0]    = '0;
    addr_pool[1]    = '1;
    addr_pool[2]    = 48'hAAAA_AAAA_AAAA;
    addr_pool[3]    = 48'h5555_5555_5555;
    for (int i = 4; i < 8; i++) addr_pool[i] = ADDR_W'(rand_wide());
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: fill the table, twice the same peer in slots 0 and 2
    put_item(CMD_ACQUIRE, addr_pool[0], '0, '0);
    put_item(CMD_ACQUIRE, addr_pool[1], '1, '1);
    put_item(CMD_ACQUIRE, addr_pool[0], '0, '0);
    for (int i = 3; i < 8; i++) put_item(CMD_ACQUIRE, addr_pool[i], '0, '0);
    put_item(CMD_ACQUIRE, addr_pool[2], '0, '0);         // table full
    put_item(CMD_SEND, '0, 3'd0, 64'd0);                   // pending stamped at zero
    put_item(CMD_SEND, '1, 3'd2, 64'd5);
    put_item(CMD_REPLY, addr_pool[0], '0, 64'd1);          // lowest slot wins
    put_item(CMD_REPLY, addr_pool[0], '0, 64'd60004);      // gap just under limit
    put_item(CMD_REPLY, addr_pool[0], '0, 64'd7);          // nothing pending
    put_item(CMD_SEND, '0, 3'd0, '1);
    put_item(CMD_SEND, '0, 3'd2, 64'd0);
    put_item(CMD_REPLY, addr_pool[0], '0, 64'd59999);      // wraps, gap at limit
    put_item(CMD_REPLY, addr_pool[0], '0, '1);             // gap negative as signed
    put_item(CMD_SEND, '0, 3'd0, 64'd100);
    put_item(CMD_SEND, '0, 3'd2, 64'd100);
    put_item(CMD_RELEASE, '0, 3'd1, '0);
    put_item(CMD_SEND, '0, 3'd1, 64'd3);                   // send on a free slot
    put_item(CMD_REPLY, addr_pool[1], '0, 64'd9);          // free slot never matches
    put_item(CMD_ACQUIRE, addr_pool[2], '0, '0);           // reuses slot 1
    put_item(CMD_REPLY, addr_pool[2], '0, 64'd10);         // acquire cleared pending
    put_item(CMD_RELEASE, '1, 3'd7, '1);

    clock_us = rand_wide();
    base     = item_cnt;
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0:       begin send_gap_pct = 16; recv_gap_pct = 71; end
        1:       begin send_gap_pct = 71; recv_gap_pct = 16; end
        default: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
      endcase
      if (ph != 1) hold_req = 1'b1;
      while (item_cnt < base + (ph + 1) * RAND_ITEMS / 3) random_step();
    end

    in_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (open_cnt != 0 && waited < 5000);
    repeat (2 * SLOT_COUNT + 8) @(negedge clk_i);

    $display("Covered %0d items (%0d acquire, %0d send, %0d reply, %0d release) over three idle mixes",
             item_cnt, cmd_cnt[CMD_ACQUIRE], cmd_cnt[CMD_SEND], cmd_cnt[CMD_REPLY],
             cmd_cnt[CMD_RELEASE]);
    $display("and two long result stalls; %0d replies matched, %0d sends gave a delay sample.",
             reply_hits, delay_samples);
    if (open_cnt != 0) $display("%0d expected result items never arrived", open_cnt);
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/rtst_pkg.sv
design/rtst_if.sv
design/rtst_ram.sv
design/rtst_ctrl.sv
design/tx_round_trip_slot_table_core.sv
dv/tx_round_trip_slot_table_core_checker.sv
dv/tx_round_trip_slot_table_core_tb.sv
